/* hw/rtl/bmm_pkg.sv */
// bmm_pkg: shared types and constants for the banked memory mapper
`default_nettype none

package bmm_pkg;

  localparam int unsigned REGION_COUNT = 8;
  localparam int unsigned BANK_W       = 9;
  localparam int unsigned OFFSET_W     = 13;

  // target memory codes
  localparam logic [1:0] TGT_ROM  = 2'd0;
  localparam logic [1:0] TGT_SRAM = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  // access codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_PAGE_MASK = 2'd0;
  localparam logic [1:0] CFG_SRAM_PAGES    = 2'd1;

  // bank number boundaries
  localparam logic [BANK_W-1:0] SRAM_FIRST_BANK = 9'h080;
  localparam logic [BANK_W-1:0] RAM_FIRST_BANK  = 9'h180;

  // address map
  localparam logic [15:0] BANK_WIN_LO  = 16'h6000;
  localparam logic [15:0] BANK_WIN_HI  = 16'h7ff0;
  localparam logic [15:0] NINTH_ADDR   = 16'h7ff8;
  localparam logic [15:0] CONTROL_ADDR = 16'h7ff9;
  localparam logic [15:0] MEM_WIN_LO   = 16'h8000;
  localparam logic [15:0] MEM_WIN_HI   = 16'hc000;

  // control byte bits
  localparam int unsigned CTRL_BANK_RD  = 2;
  localparam int unsigned CTRL_CTRL_RD  = 3;
  localparam int unsigned CTRL_NINTH_RD = 4;

  // bank translation result
  typedef struct packed {
    logic [1:0]        tgt;
    logic [BANK_W-1:0] page;
  } map_t;

endpackage

`default_nettype wire

/* hw/rtl/bmm_xlate.sv */
// bmm_xlate: translation of a bank number into a target memory and page
`default_nettype none

module bmm_xlate (
  input  wire logic [bmm_pkg::BANK_W-1:0] bank,
  input  wire logic [bmm_pkg::BANK_W-1:0] rom_page_mask,
  input  wire logic [3:0]                 sram_pages,
  output bmm_pkg::map_t                   map
);
  import bmm_pkg::*;

  logic [BANK_W:0]   sram_end;
  logic              sram_hit;
  logic [BANK_W-1:0] sram_page;
  logic [BANK_W-1:0] ram_page;
  logic [3:0]        sram_mask;

  // sram window is 0x80 up to 0x80 plus the sram size
  assign sram_end  = {1'b0, SRAM_FIRST_BANK} + {{(BANK_W-3){1'b0}}, sram_pages};
  assign sram_hit  = (sram_pages != 4'd0) && (bank >= SRAM_FIRST_BANK) &&
                     ({1'b0, bank} < sram_end);
  assign sram_mask = sram_pages - 4'd1;
  assign sram_page = (bank - SRAM_FIRST_BANK) & {{(BANK_W-4){1'b0}}, sram_mask};
  assign ram_page  = bank - RAM_FIRST_BANK;

  // priority: sram, then ram, then rom
  always_comb begin
    if (sram_hit) begin
      map.tgt  = TGT_SRAM;
      map.page = sram_page;
    end else if (bank >= RAM_FIRST_BANK) begin
      map.tgt  = TGT_RAM;
      map.page = ram_page;
    end else begin
      map.tgt  = TGT_ROM;
      map.page = bank & rom_page_mask;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/banked_memory_mapper_8k_core.sv */
// banked_memory_mapper_8k_core: bus access translator with eight 8K bank windows
//
//  channel   | ports                                             | transaction
//  ----------+---------------------------------------------------+--------------------------
//  access    | start, busy, opcode, bus_address, write_value     | start high, busy low
//  result    | done, register_hit, register_data, target,        | done high for one cycle
//            | page_number, page_offset, memory_write, memory_data|
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data         | cfg_valid and cfg_ready
//
// An access is taken into an input register, decoded and translated in the
// next cycle, and its result then goes through the result register onto done.
// One access is accepted every cycle; busy stays low.
// Bank table and control byte update as each access is decoded, so a later
// access sees the effect of every earlier one.
// Synchronous reset clears banks, control byte and the pipeline valid flags;
// the results are never held off by the receiver.
`default_nettype none

module banked_memory_mapper_8k_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [15:0] bus_address,
  input  wire logic [7:0]  write_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  output logic             done,
  output logic             register_hit,
  output logic [7:0]       register_data,
  output logic [1:0]       target,
  output logic [8:0]       page_number,
  output logic [12:0]      page_offset,
  output logic             memory_write,
  output logic [7:0]       memory_data
);
  import bmm_pkg::*;

  // configuration registers
  logic [BANK_W-1:0] rom_page_mask;
  logic [3:0]        sram_pages;

  // mapper state
  logic [BANK_W-1:0] bank_table [REGION_COUNT];
  logic [BANK_W-1:0] bank_table_next [REGION_COUNT];
  logic [7:0]        control_byte;
  logic [7:0]        control_byte_next;

  // input register
  logic        in_valid;
  logic        in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_val;

  // decode signals
  logic [2:0]        region;
  logic [2:0]        wr_region;
  logic [BANK_W-1:0] cur_bank;
  map_t              map;
  logic [7:0]        ninth_bits;

  logic              hit_next;
  logic [7:0]        rdata_next;
  logic [1:0]        tgt_next;
  logic [BANK_W-1:0] page_next;
  logic [12:0]       offs_next;
  logic              mwr_next;
  logic [7:0]        mdata_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_page_mask <= 9'h1ff;
      sram_pages    <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROM_PAGE_MASK: rom_page_mask <= cfg_data;
        CFG_SRAM_PAGES:    sram_pages    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // capture the access
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_op   <= opcode;
      in_addr <= bus_address;
      in_val  <= write_value;
    end
  end

  assign region   = in_addr[15:13];
  assign cur_bank = bank_table[region];

  bmm_xlate u_xlate (
    .bank          (cur_bank),
    .rom_page_mask (rom_page_mask),
    .sram_pages    (sram_pages),
    .map           (map)
  );

  // packed ninth bits of all banks
  always_comb begin
    for (int i = 0; i < REGION_COUNT; i++) begin
      ninth_bits[i] = bank_table[i][BANK_W-1];
    end
  end

  // bank write region, with regions five and six swapped
  always_comb begin
    wr_region = in_addr[12:10];
    if (wr_region inside {3'd5, 3'd6}) begin
      wr_region = wr_region ^ 3'd3;
    end
  end

  // decode and translate
  always_comb begin
    hit_next          = 1'b0;
    rdata_next        = 8'd0;
    tgt_next          = TGT_NONE;
    page_next         = '0;
    offs_next         = '0;
    mwr_next          = 1'b0;
    mdata_next        = 8'd0;
    bank_table_next   = bank_table;
    control_byte_next = control_byte;
    if (in_op == OP_READ) begin
      if (control_byte[CTRL_BANK_RD] && in_addr >= BANK_WIN_HI && in_addr < NINTH_ADDR) begin
        hit_next   = 1'b1;
        rdata_next = bank_table[in_addr[2:0]][7:0];
      end else if (control_byte[CTRL_NINTH_RD] && in_addr == NINTH_ADDR) begin
        hit_next   = 1'b1;
        rdata_next = ninth_bits;
      end else if (control_byte[CTRL_CTRL_RD] && in_addr == CONTROL_ADDR) begin
        hit_next   = 1'b1;
        rdata_next = control_byte;
      end else begin
        tgt_next  = map.tgt;
        page_next = map.page;
        offs_next = in_addr[OFFSET_W-1:0];
      end
    end else if (in_addr >= BANK_WIN_LO && in_addr < BANK_WIN_HI) begin
      bank_table_next[wr_region] = {bank_table[wr_region][BANK_W-1], in_val};
    end else if (in_addr == NINTH_ADDR) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        bank_table_next[i] = {in_val[i], bank_table[i][7:0]};
      end
    end else if (in_addr == CONTROL_ADDR) begin
      control_byte_next = in_val;
    end else if (in_addr >= MEM_WIN_LO && in_addr < MEM_WIN_HI) begin
      if (map.tgt != TGT_ROM) begin
        tgt_next   = map.tgt;
        page_next  = map.page;
        offs_next  = in_addr[OFFSET_W-1:0];
        mwr_next   = 1'b1;
        mdata_next = in_val;
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        bank_table[i] <= '0;
      end
      control_byte <= 8'd0;
    end else if (in_valid) begin
      bank_table   <= bank_table_next;
      control_byte <= control_byte_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      register_hit  <= hit_next;
      register_data <= rdata_next;
      target        <= tgt_next;
      page_number   <= page_next;
      page_offset   <= offs_next;
      memory_write  <= mwr_next;
      memory_data   <= mdata_next;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking testbench for the banked memory mapper core
`timescale 1ns / 100ps

module tb_top;
  import bmm_pkg::*;

  // the two index codes that select no register
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  // regions 5 and 6 trade places on bank writes
  localparam logic [2:0] SWAP_REGION_A = 3'd5;
  localparam logic [2:0] SWAP_REGION_B = 3'd6;

  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic        hit;
    logic [7:0]  rdata;
    logic [1:0]  tgt;
    logic [8:0]  page;
    logic [12:0] offs;
    logic        mwr;
    logic [7:0]  mdata;
  } access_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [15:0] bus_address;
  logic [7:0]  write_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        done;
  logic        register_hit;
  logic [7:0]  register_data;
  logic [1:0]  target;
  logic [8:0]  page_number;
  logic [12:0] page_offset;
  logic        memory_write;
  logic [7:0]  memory_data;

  // mirror of the mapper state and its configuration
  logic [8:0]  bank_regs [REGION_COUNT];
  logic [7:0]  ctrl_reg;
  logic [8:0]  rom_mask_reg;
  logic [3:0]  sram_pages_reg;

  access_result_t pending_results [$];
  access_result_t oldest_result;
  int unsigned    mismatch_count;
  int unsigned    idle_count;
  int unsigned    burst_left;

  banked_memory_mapper_8k_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .bus_address  (bus_address),
    .write_value  (write_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .register_hit (register_hit),
    .register_data(register_data),
    .target       (target),
    .page_number  (page_number),
    .page_offset  (page_offset),
    .memory_write (memory_write),
    .memory_data  (memory_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // bank number to target memory and page
  function automatic map_t map_bank_number(input logic [8:0] bank);
    map_t       m;
    logic [8:0] sram_off;
    sram_off = bank - SRAM_FIRST_BANK;
    if (sram_pages_reg != 4'd0 && bank >= SRAM_FIRST_BANK &&
        int'(bank) < int'(SRAM_FIRST_BANK) + int'(sram_pages_reg)) begin
      m.tgt  = TGT_SRAM;
      m.page = sram_off & {5'd0, sram_pages_reg - 4'd1};
    end else if (bank >= RAM_FIRST_BANK) begin
      m.tgt  = TGT_RAM;
      m.page = bank - RAM_FIRST_BANK;
    end else begin
      m.tgt  = TGT_ROM;
      m.page = bank & rom_mask_reg;
    end
    return m;
  endfunction

  // expected result of one access, updating the mirrored state
  function automatic access_result_t predict_access(input logic op, input logic [15:0] addr,
                                                    input logic [7:0] val);
    access_result_t res;
    map_t           m;
    logic [2:0]     r;
    int             i;
    res     = '0;
    res.tgt = TGT_NONE;
    m       = map_bank_number(bank_regs[addr[15:13]]);
    if (op == OP_READ) begin
      if (ctrl_reg[CTRL_BANK_RD] && addr >= BANK_WIN_HI && addr < NINTH_ADDR) begin
        res.hit   = 1'b1;
        res.rdata = bank_regs[addr[2:0]][7:0];
      end else if (ctrl_reg[CTRL_NINTH_RD] && addr == NINTH_ADDR) begin
        res.hit = 1'b1;
        for (i = 0; i < REGION_COUNT; i++)
          res.rdata[i] = bank_regs[i][8];
      end else if (ctrl_reg[CTRL_CTRL_RD] && addr == CONTROL_ADDR) begin
        res.hit   = 1'b1;
        res.rdata = ctrl_reg;
      end else begin
        res.tgt  = m.tgt;
        res.page = m.page;
        res.offs = addr[12:0];
      end
    end else if (addr >= BANK_WIN_LO && addr < BANK_WIN_HI) begin
      r = addr[12:10];
      if (r == SWAP_REGION_A)
        r = SWAP_REGION_B;
      else if (r == SWAP_REGION_B)
        r = SWAP_REGION_A;
      bank_regs[r][7:0] = val;
    end else if (addr == NINTH_ADDR) begin
      for (i = 0; i < REGION_COUNT; i++)
        bank_regs[i][8] = val[i];
    end else if (addr == CONTROL_ADDR) begin
      ctrl_reg = val;
    end else if (addr >= MEM_WIN_LO && addr < MEM_WIN_HI && m.tgt != TGT_ROM) begin
      res.tgt   = m.tgt;
      res.page  = m.page;
      res.offs  = addr[12:0];
      res.mwr   = 1'b1;
      res.mdata = val;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // result checker: each strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobed with no transaction outstanding");
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("register_hit", register_hit, oldest_result.hit);
        check_field("register_data", register_data, oldest_result.rdata);
        check_field("target", target, oldest_result.tgt);
        check_field("page_number", page_number, oldest_result.page);
        check_field("page_offset", page_offset, oldest_result.offs);
        check_field("memory_write", memory_write, oldest_result.mwr);
        check_field("memory_data", memory_data, oldest_result.mdata);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready))
      idle_count = 0;
    else
      idle_count++;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one access transaction
  task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] val);
    @(negedge clk);
    start       = 1'b1;
    opcode      = op;
    bus_address = addr;
    write_value = val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_access(op, addr, val));
  endtask

  // sender gap with junk on the payload
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start       = 1'b0;
      opcode      = 1'($urandom);
      bus_address = 16'($urandom);
      write_value = 8'($urandom);
    end
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic wait_until_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one configuration transaction
  task automatic cfg_write(input logic [1:0] idx, input logic [8:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROM_PAGE_MASK: rom_mask_reg   = data;
      CFG_SRAM_PAGES:    sram_pages_reg = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // bank byte leaning towards the sram window
  function automatic logic [7:0] pick_bank_byte();
    logic [7:0] v;
    if ($urandom_range(0, 1) == 0)
      v = 8'h80 + 8'($urandom_range(0, 15));
    else
      v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // mostly mapper programming and window traffic, some noise
  task automatic run_random_items(input int unsigned n);
    int unsigned i;
    int unsigned pick;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  val;
    for (i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0)
          idle_cycles($urandom_range(4, 12));
        else
          idle_cycles($urandom_range(1, 3));
        burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      val  = 8'($urandom_range(0, 255));
      if (pick < 20) begin
        op   = OP_WRITE;
        addr = BANK_WIN_LO + 16'($urandom_range(0, 16'h1fef));
        val  = pick_bank_byte();
      end else if (pick < 27) begin
        op   = OP_WRITE;
        addr = NINTH_ADDR;
      end else if (pick < 32) begin
        op   = OP_WRITE;
        addr = CONTROL_ADDR;
        if ($urandom_range(0, 3) != 0) begin
          val[CTRL_BANK_RD]  = 1'b1;
          val[CTRL_CTRL_RD]  = 1'b1;
          val[CTRL_NINTH_RD] = 1'b1;
        end
      end else if (pick < 47) begin
        op   = OP_READ;
        addr = BANK_WIN_HI + 16'($urandom_range(0, 15));
      end else if (pick < 67) begin
        op   = OP_WRITE;
        addr = MEM_WIN_LO + 16'($urandom_range(0, 16'h3fff));
      end else if (pick < 87) begin
        op   = OP_READ;
        addr = 16'($urandom);
      end else if (pick < 95) begin
        op   = OP_WRITE;
        addr = 16'($urandom);
      end else begin
        op   = OP_WRITE;
        addr = BANK_WIN_HI + 16'($urandom_range(0, 15));
      end
      send_access(op, addr, val);
    end
  endtask

  // reads and a rom write straight after reset
  task automatic test_reset_defaults();
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_READ, 16'hffff, 8'hff);
    send_access(OP_READ, NINTH_ADDR, 8'h00);
    send_access(OP_WRITE, MEM_WIN_LO, 8'h5a);
  endtask

  // bank, ninth-bit and control writes, then register read-back
  task automatic test_mapper_registers();
    send_access(OP_WRITE, 16'h6000, 8'h81);
    send_access(OP_WRITE, 16'h7400, 8'h66);
    send_access(OP_WRITE, 16'h7bff, 8'h55);
    send_access(OP_WRITE, 16'h7fef, 8'hff);
    send_access(OP_WRITE, NINTH_ADDR, 8'ha5);
    send_access(OP_WRITE, CONTROL_ADDR, 8'h1c);
    send_access(OP_READ, 16'h7ff0, 8'h00);
    send_access(OP_READ, 16'h7ff7, 8'h00);
    send_access(OP_READ, NINTH_ADDR, 8'h00);
    send_access(OP_READ, CONTROL_ADDR, 8'h00);
    send_access(OP_WRITE, 16'h7ff0, 8'h3c);
    send_access(OP_WRITE, 16'h7fff, 8'hc3);
    send_access(OP_WRITE, CONTROL_ADDR, 8'h00);
    send_access(OP_READ, 16'h7ff5, 8'h00);
  endtask

  // sram, ram and rom-backed writes in the memory window
  task automatic test_memory_windows();
    send_access(OP_WRITE, 16'h7000, 8'h83);
    send_access(OP_WRITE, 16'h8000, 8'h5a);
    send_access(OP_WRITE, 16'h9fff, 8'ha5);
    send_access(OP_WRITE, 16'ha000, 8'h77);
    send_access(OP_WRITE, 16'h7800, 8'hff);
    send_access(OP_WRITE, 16'hbfff, 8'h01);
    send_access(OP_WRITE, MEM_WIN_HI, 8'h99);
    send_access(OP_READ, 16'hbfff, 8'h00);
    send_access(OP_READ, 16'h8000, 8'h00);
  endtask

  // writes to indexes with no register behind them
  task automatic test_unused_config_index();
    wait_until_idle();
    cfg_write(CFG_SPARE_A, 9'h1ff);
    cfg_write(CFG_SPARE_B, 9'h155);
    run_random_items(40);
  endtask

  task automatic run_config_phase(input logic [8:0] mask, input logic [8:0] sram,
                                  input int unsigned n);
    wait_until_idle();
    cfg_write(CFG_ROM_PAGE_MASK, mask);
    cfg_write(CFG_SRAM_PAGES, sram);
    run_random_items(n);
  endtask

  // rom and sram sizes across their range, odd sizes included
  task automatic test_config_sweep();
    run_config_phase(9'd3, 9'd0, 100);
    run_config_phase(9'd511, 9'd8, 100);
    run_config_phase(9'd63, 9'd1, 100);
    run_config_phase(9'd15, 9'd2, 100);
    run_config_phase(9'd511, 9'd3, 100);
    run_config_phase(9'd127, 9'd15, 100);
    run_config_phase(9'h0a5, 9'd9, 100);
    run_config_phase(9'd0, 9'd5, 100);
    run_config_phase(9'd255, 9'h1f6, 100);
    run_config_phase(9'd31, 9'd7, 100);
  endtask

  // long stretch back at the reset sizes
  task automatic test_random_traffic();
    run_config_phase(9'd511, 9'd4, 330);
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    opcode         = OP_READ;
    bus_address    = '0;
    write_value    = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_ROM_PAGE_MASK;
    cfg_data       = '0;
    ctrl_reg       = '0;
    rom_mask_reg   = 9'd511;
    sram_pages_reg = 4'd4;
    mismatch_count = 0;
    idle_count     = 0;
    burst_left     = 0;
    for (int i = 0; i < REGION_COUNT; i++)
      bank_regs[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_mapper_registers();
    test_memory_windows();
    test_unused_config_index();
    test_config_sweep();
    test_random_traffic();
    wait_until_idle();

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
